// ===== design/mmct_pkg.sv =====
// shared types and constants for the multiset mode count tracker
package mmct_pkg;

    localparam int SYM_W  = 12;
    localparam int MODE_W = 13;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // strobes from the controller to the datapath, one-cycle but for clr
    typedef struct packed {
        logic clr;   // clearing pass, zero one entry of each table
        logic cap;   // input transfer, capture cmd and symbol
        logic look;  // read the symbol count
        logic eval;  // check the item, write the new symbol count, read old bucket
        logic dec;   // update the old bucket, read the new bucket
        logic inc;   // update the new bucket
        logic fin;   // load the result register
    } t_cmd;

    typedef struct packed {
        logic clr_done;  // last entry of the clearing pass
        logic item_ok;   // item is applied, valid during eval
        logic out_busy;  // result register full and not taken this cycle
    } t_sts;

endpackage

// ===== design/mmct_if.sv =====
// valid/ready channel interfaces for items and results
interface mmct_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [mmct_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output cmd, output symbol, input ready);
    modport sink   (input valid, input cmd, input symbol, output ready);
endinterface

interface mmct_out_if;
    logic                        valid;
    logic                        ready;
    logic [mmct_pkg::MODE_W-1:0] mode_count;
    logic                        error;

    modport source (output valid, output mode_count, output error, input ready);
    modport sink   (input valid, input mode_count, input error, output ready);
endinterface

// ===== design/mmct_ram.sv =====
// generic single-port-write ram with registered read
module mmct_ram #(
    parameter int   WIDTH = 8,
    parameter int   DEPTH = 16,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mmct_ctrl.sv =====
// controller state machine for the mode count tracker
module mmct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mmct_pkg::t_sts i_sts,
    output mmct_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_LOOK  = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_DEC   = 7'b0010000,
        ST_INC   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.item_ok ? ST_DEC : ST_FIN;
            end
            ST_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = ST_INC;
            end
            ST_INC: begin
                o_cmd.inc = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== design/mmct_dp.sv =====
// datapath: symbol count table, count-of-counts table, maximum and result register
module mmct_dp #(
    parameter int SYMBOL_COUNT = 4096,
    parameter int COUNT_LIMIT  = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mmct_pkg::t_cmd              i_cmd,
    output mmct_pkg::t_sts              o_sts,
    input  logic                        i_item_cmd,
    input  logic [mmct_pkg::SYM_W-1:0]  i_item_symbol,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [mmct_pkg::MODE_W-1:0] o_mode_count,
    output logic                        o_error
);

    localparam int AW    = $clog2(SYMBOL_COUNT);
    localparam int CW    = $clog2(COUNT_LIMIT + 1);
    localparam int NW    = $clog2(SYMBOL_COUNT + 1);
    localparam int CLR_N = (SYMBOL_COUNT > COUNT_LIMIT + 1) ? SYMBOL_COUNT : COUNT_LIMIT + 1;
    localparam int CLW   = $clog2(CLR_N);
    localparam int SW    = mmct_pkg::SYM_W;
    localparam int MW    = mmct_pkg::MODE_W;

    logic          r_cmd;
    logic [SW-1:0] r_sym;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_nxt;
    logic          r_ok;
    logic [CW-1:0] r_max;
    logic [CLW-1:0] r_clr;
    logic          r_out_valid;
    logic [MW-1:0] r_out_mode;
    logic          r_out_err;

    logic [AW-1:0] sym_addr;
    logic          in_range;
    logic [CW-1:0] sym_q;
    logic [NW-1:0] coc_q;
    logic          item_ok;
    logic [CW-1:0] nxt_cnt;

    logic          sym_we;
    logic [AW-1:0] sym_waddr;
    logic [CW-1:0] sym_wdata;
    logic          coc_we;
    logic          coc_re;
    logic [CW-1:0] coc_waddr;
    logic [NW-1:0] coc_wdata;
    logic [CW-1:0] coc_raddr;

    assign sym_addr = AW'(r_sym);
    assign in_range = (32'(r_sym) < 32'(SYMBOL_COUNT));

    // insert needs room below the limit, remove needs a copy present
    assign item_ok = in_range &&
                     ((r_cmd == mmct_pkg::CMD_INSERT) ? (sym_q < CW'(COUNT_LIMIT))
                                                      : (sym_q != '0));
    assign nxt_cnt = (r_cmd == mmct_pkg::CMD_INSERT) ? (sym_q + CW'(1)) : (sym_q - CW'(1));

    // symbol count table
    always_comb begin
        if (i_cmd.clr) begin
            sym_we    = (32'(r_clr) < 32'(SYMBOL_COUNT));
            sym_waddr = AW'(r_clr);
            sym_wdata = '0;
        end else begin
            sym_we    = i_cmd.eval && item_ok;
            sym_waddr = sym_addr;
            sym_wdata = nxt_cnt;
        end
    end

    mmct_ram #(
        .WIDTH (CW),
        .DEPTH (SYMBOL_COUNT)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (sym_wdata),
        .i_re    (i_cmd.look),
        .i_raddr (sym_addr),
        .o_rdata (sym_q)
    );

    // count-of-counts table, bucket zero is never written outside the clear
    always_comb begin
        coc_re    = i_cmd.eval || i_cmd.dec;
        coc_raddr = i_cmd.eval ? sym_q : r_nxt;
        if (i_cmd.clr) begin
            coc_we    = (32'(r_clr) < 32'(COUNT_LIMIT + 1));
            coc_waddr = CW'(r_clr);
            coc_wdata = '0;
        end else if (i_cmd.dec) begin
            coc_we    = (r_cnt != '0);
            coc_waddr = r_cnt;
            coc_wdata = coc_q - NW'(1);
        end else begin
            coc_we    = i_cmd.inc && (r_nxt != '0);
            coc_waddr = r_nxt;
            coc_wdata = coc_q + NW'(1);
        end
    end

    mmct_ram #(
        .WIDTH (NW),
        .DEPTH (COUNT_LIMIT + 1)
    ) u_coc_ram (
        .i_clk   (i_clk),
        .i_we    (coc_we),
        .i_waddr (coc_waddr),
        .i_wdata (coc_wdata),
        .i_re    (coc_re),
        .i_raddr (coc_raddr),
        .o_rdata (coc_q)
    );

    // item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_cmd <= i_item_cmd;
            r_sym <= i_item_symbol;
        end
        if (i_cmd.eval) begin
            r_cnt <= sym_q;
            r_nxt <= nxt_cnt;
            r_ok  <= item_ok;
        end
    end

    // clear sweep counter and running maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_max <= '0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + CLW'(1);
            end
            if (i_cmd.dec && (r_cmd == mmct_pkg::CMD_REMOVE) && (r_cnt == r_max) &&
                (coc_q == NW'(1))) begin
                r_max <= r_max - CW'(1);
            end else if (i_cmd.inc && (r_cmd == mmct_pkg::CMD_INSERT) && (r_nxt > r_max)) begin
                r_max <= r_nxt;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_out_mode <= MW'(r_max);
            r_out_err  <= !r_ok;
        end
    end

    assign o_sts.clr_done = (r_clr == CLW'(CLR_N - 1));
    assign o_sts.item_ok  = item_ok;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_mode_count = r_out_mode;
    assign o_error      = r_out_err;

endmodule

// ===== design/multiset_mode_count_tracker_unit.sv =====
// Multiset mode count tracker: each item inserts (cmd 0) or removes (cmd 1) one copy of a
// symbol, and the matching result gives the highest multiplicity of any symbol after that
// step plus an error flag. A remove of an absent symbol, an insert of a symbol already at
// COUNT_LIMIT copies, or a symbol at or above SYMBOL_COUNT is ignored, flagged with error = 1,
// and reports the unchanged maximum. One item is in work at a time: after its input transfer
// an applied item steps through the look, eval, dec, inc and fin states to the result load,
// and only then can the next input transfer follow; an ignored one goes from eval to fin.
// The steps come from keeping both tables in rams with one write port and a registered read,
// so the update is a chain of one count read, one old-bucket access and one new-bucket access.
// The result sits in an output register, so the next item is taken while an earlier result
// waits; the block stalls only when a second result is ready and the first has not been taken.
// After reset a clearing pass zeroes both tables, one entry of each per cycle, over the
// address range of the larger table; input ready stays low until it ends.
module multiset_mode_count_tracker_unit #(
    parameter int SYMBOL_COUNT = 4096,
    parameter int COUNT_LIMIT  = 4096
) (
    input logic       i_clk,
    input logic       i_rst_n,
    mmct_in_if.sink   i_in,
    mmct_out_if.source o_out
);

    // command strobes and status flags between controller and datapath
    mmct_pkg::t_cmd ctrl_cmd;
    mmct_pkg::t_sts dp_sts;

    // controller: clearing pass, item sequencing, result handoff
    mmct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctrl_cmd)
    );

    // datapath: both count tables, the running maximum and the result register
    mmct_dp #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_LIMIT  (COUNT_LIMIT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .o_sts         (dp_sts),
        .i_item_cmd    (i_in.cmd),
        .i_item_symbol (i_in.symbol),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_mode_count  (o_out.mode_count),
        .o_error       (o_out.error)
    );

endmodule

// ===== tb/sv/mmct_mode_checker.sv =====
// transfer monitor, multiplicity predictor and result comparison for the mode tracker
`timescale 1ns / 1ps

module mmct_mode_checker #(
    parameter int SYMBOL_COUNT = 4096,
    parameter int COUNT_LIMIT  = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mmct_in_if   i_items,
    mmct_out_if  i_results,
    output int   o_pending,
    output int   o_fail_count
);

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [mmct_pkg::MODE_W-1:0] mode_count;
        logic                        error;
    } t_mode_result;

    // shadow of the block's tables
    logic [mmct_pkg::MODE_W-1:0] sym_mult [SYMBOL_COUNT];
    logic [mmct_pkg::MODE_W-1:0] mult_pop [COUNT_LIMIT + 1];
    logic [mmct_pkg::MODE_W-1:0] peak_mult;

    t_mode_result expected_modes [$];
    int           fail_count;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("[%0t] mode tracker mismatch: %s", $time, msg);
        end
    endtask

    // applies one insert or remove and returns the mode after it
    function automatic t_mode_result track_multiset(input logic op,
                                                    input logic [mmct_pkg::SYM_W-1:0] sym);
        int           mult;
        logic         applied;
        t_mode_result res;
        applied = 1'b0;
        if (int'(sym) < SYMBOL_COUNT) begin
            mult = int'(sym_mult[sym]);
            if (op == mmct_pkg::CMD_INSERT) begin
                if (mult < COUNT_LIMIT) begin
                    if (mult > 0) mult_pop[mult] = mult_pop[mult] - 1'b1;
                    mult++;
                    mult_pop[mult] = mult_pop[mult] + 1'b1;
                    sym_mult[sym]  = mmct_pkg::MODE_W'(mult);
                    if (mult > int'(peak_mult)) peak_mult = mmct_pkg::MODE_W'(mult);
                    applied = 1'b1;
                end
            end else if (mult > 0 && mult <= COUNT_LIMIT) begin
                mult_pop[mult] = mult_pop[mult] - 1'b1;
                // last symbol at the peak leaves it, peak drops by one
                if (mult == int'(peak_mult) && mult_pop[mult] == '0) begin
                    peak_mult = peak_mult - 1'b1;
                end
                mult--;
                if (mult > 0) mult_pop[mult] = mult_pop[mult] + 1'b1;
                sym_mult[sym] = mmct_pkg::MODE_W'(mult);
                applied = 1'b1;
            end
        end
        res.mode_count = peak_mult;
        res.error      = ~applied;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mode_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SYMBOL_COUNT; i++) sym_mult[i] = '0;
            for (int i = 0; i <= COUNT_LIMIT; i++) mult_pop[i] = '0;
            peak_mult = '0;
            expected_modes.delete();
        end else begin
            // compare before queueing, a result never belongs to an item taken at the same edge
            if (i_results.valid && i_results.ready) begin
                if (expected_modes.size() == 0) begin
                    report_mismatch($sformatf("result mode_count=%0d error=%0b with no item pending",
                                              i_results.mode_count, i_results.error));
                end else begin
                    want = expected_modes.pop_front();
                    if (i_results.mode_count !== want.mode_count) begin
                        report_mismatch($sformatf("mode_count got %0d expected %0d",
                                                  i_results.mode_count, want.mode_count));
                    end
                    if (i_results.error !== want.error) begin
                        report_mismatch($sformatf("error got %0b expected %0b",
                                                  i_results.error, want.error));
                    end
                end
            end
            if (i_items.valid && i_items.ready) begin
                expected_modes.push_back(track_multiset(i_items.cmd, i_items.symbol));
            end
        end
        o_pending = expected_modes.size();
    end

endmodule

// ===== tb/sv/tb_multiset_mode_count_tracker_unit.sv =====
// stimulus, flow control and verdict for the multiset mode count tracker
`timescale 1ns / 1ps

module tb_multiset_mode_count_tracker_unit;

    localparam int SYMBOL_COUNT   = 4096;
    localparam int COUNT_LIMIT    = 4096;
    // the limit covers the clearing pass, which runs with no transfer
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_LEN      = 40;
    localparam int PHASE_ITEMS    = 440;

    logic clk = 1'b0;
    logic rst_n;

    // flow-control knobs, percent of cycles spent idle or stalled
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off, requested by stimulus and served by the receiver process
    int hold_requests  = 0;
    int hold_served    = 0;
    int idle_cycles    = 0;
    int pending;
    int fail_count;

    int phase_send [4] = '{0, 46, 0, 16};
    int phase_recv [4] = '{0, 0, 46, 16};

    always #5 clk = ~clk;

    mmct_in_if  item_if ();
    mmct_out_if result_if ();

    multiset_mode_count_tracker_unit #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_LIMIT  (COUNT_LIMIT)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (item_if),
        .o_out   (result_if)
    );

    mmct_mode_checker #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .COUNT_LIMIT  (COUNT_LIMIT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_items      (item_if),
        .i_results    (result_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // one insert or remove; random idle cycles first, then hold until the transfer
    task automatic send_op(input logic op, input logic [mmct_pkg::SYM_W-1:0] sym);
        while ($urandom_range(99) < send_idle_pct) begin
            item_if.valid <= 1'b0;
            @(negedge clk);
        end
        item_if.valid  <= 1'b1;
        item_if.cmd    <= op;
        item_if.symbol <= sym;
        do @(posedge clk); while (!item_if.ready);
        @(negedge clk);
    endtask

    // stop offering and let every pending result come back
    task automatic wait_results_drained();
        item_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // bursts over a small pool of symbols: insert-heavy first, remove-heavy after,
    // so counts climb, tie and fall back; a few items use any symbol as noise
    task automatic run_bursts(input int count);
        logic [mmct_pkg::SYM_W-1:0] pool [6];
        logic [mmct_pkg::SYM_W-1:0] sym;
        logic                       op;
        int                         pool_n;
        int                         insert_pct;
        pool_n = 1;
        for (int i = 0; i < count; i++) begin
            if (i % BURST_LEN == 0) begin
                pool_n = $urandom_range(1, 6);
                for (int j = 0; j < 6; j++) begin
                    case ($urandom_range(7))
                        0:       pool[j] = '0;
                        1:       pool[j] = '1;
                        default: pool[j] = mmct_pkg::SYM_W'($urandom);
                    endcase
                end
            end
            insert_pct = (i % BURST_LEN < BURST_LEN / 2) ? 75 : 25;
            if ($urandom_range(99) < 85) begin
                sym = pool[$urandom_range(pool_n - 1)];
            end else begin
                sym = mmct_pkg::SYM_W'($urandom);
            end
            op = ($urandom_range(99) < insert_pct) ? mmct_pkg::CMD_INSERT
                                                   : mmct_pkg::CMD_REMOVE;
            send_op(op, sym);
        end
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        result_if.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_requests) begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served++;
            end else begin
                result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog: too many cycles without a transfer on either channel
    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        item_if.valid  <= 1'b0;
        item_if.cmd    <= mmct_pkg::CMD_INSERT;
        item_if.symbol <= '0;
        rst_n          <= 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-set remove, both symbol extremes, peak rise, peak drop,
        // remove of the last copy, repeated absent removes, tie at the peak
        send_op(mmct_pkg::CMD_REMOVE, '0);
        send_op(mmct_pkg::CMD_INSERT, '0);
        send_op(mmct_pkg::CMD_INSERT, '1);
        send_op(mmct_pkg::CMD_INSERT, '0);
        send_op(mmct_pkg::CMD_INSERT, 12'hAAA);
        send_op(mmct_pkg::CMD_INSERT, 12'h555);
        send_op(mmct_pkg::CMD_REMOVE, '1);
        send_op(mmct_pkg::CMD_REMOVE, '0);
        send_op(mmct_pkg::CMD_REMOVE, '0);
        send_op(mmct_pkg::CMD_REMOVE, '0);
        send_op(mmct_pkg::CMD_REMOVE, 12'hAAA);
        send_op(mmct_pkg::CMD_REMOVE, 12'h555);
        send_op(mmct_pkg::CMD_REMOVE, 12'h555);
        send_op(mmct_pkg::CMD_INSERT, 12'h800);
        send_op(mmct_pkg::CMD_INSERT, 12'h800);
        send_op(mmct_pkg::CMD_INSERT, 12'h001);
        send_op(mmct_pkg::CMD_INSERT, 12'h001);
        send_op(mmct_pkg::CMD_REMOVE, 12'h800);
        send_op(mmct_pkg::CMD_REMOVE, 12'h001);
        send_op(mmct_pkg::CMD_REMOVE, 12'h800);
        send_op(mmct_pkg::CMD_REMOVE, 12'h001);
        wait_results_drained();

        // back-pressure: the receiver holds off while items keep coming, so the
        // result register fills and input ready drops
        hold_requests++;
        run_bursts(60);
        wait_results_drained();

        // idling phases, with a full drain between them
        foreach (phase_send[p]) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            run_bursts(PHASE_ITEMS);
            wait_results_drained();
        end

        // catch any stray result that follows the last expected one
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
